// ===== rtl/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;
   typedef enum logic [3:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
      OP_EQ  = 4'd4, OP_NE  = 4'd5, OP_LT  = 4'd6, OP_LE  = 4'd7,
      OP_GT  = 4'd8, OP_GE  = 4'd9, OP_INC = 4'd10, OP_DEC = 4'd11,
      OP_NEG = 4'd12
   } opcode_type;
   localparam int NUM_W = 33;
   localparam int DEN_W = 31;
endpackage

// ===== rtl/rau_serdiv.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, remainder kept.
`timescale 1ns / 1ps
module rau_serdiv #(
   parameter int W = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quot,
   output logic [W-1:0] rem
);
   localparam int CW = $clog2(W + 1);
   logic [W-1:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [W:0] trial;

   // shift one dividend bit into the remainder and try a subtract
   always_comb begin
      trial = {r_ff, q_ff[W-1]} - {1'b0, d_ff};
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor;
         cnt_in = CW'(W); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            r_in = trial[W-1:0];
            q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = {r_ff[W-2:0], q_ff[W-1]};
            q_in = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
      if (reset) begin
         cnt_ff <= '0; busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = r_ff;
endmodule

// ===== rtl/rau_sermul.sv =====
// Shift-add multiplier: one multiplier bit per cycle.
`timescale 1ns / 1ps
module rau_sermul #(
   parameter int W = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   mcand,
   input  logic [W-1:0]   mplier,
   output logic           done,
   output logic [2*W-1:0] prod
);
   localparam int CW = $clog2(W + 1);
   logic [2*W-1:0] p_ff, p_in, m_ff, m_in;
   logic [W-1:0] b_ff, b_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;

   // add the shifted multiplicand for each set multiplier bit
   always_comb begin
      p_in = p_ff; m_in = m_ff; b_in = b_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         p_in = '0; m_in = {{W{1'b0}}, mcand}; b_in = mplier;
         cnt_in = CW'(W); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) p_in = p_ff + m_ff;
         m_in = {m_ff[2*W-2:0], 1'b0};
         b_in = {1'b0, b_ff[W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in; m_ff <= m_in; b_ff <= b_in;
      if (reset) begin
         cnt_ff <= '0; busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = p_ff;
endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: top level with operation sequencer and output register.
// Sequence: data dependent: up to three multiplies, a sum, then Euclid's algorithm with
// one divide per modulo step, plus two final divides of numerator and denominator.
// Throughput: one item at a time; the next item is taken once the result leaves.
// Reset: synchronous, active high; clears the sequencer and the output valid.
`timescale 1ns / 1ps
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [3:0]               req_opcode,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_den,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [rau_pkg::NUM_W-1:0] rsp_res_num,
   output logic [rau_pkg::DEN_W-1:0] rsp_res_den,
   output logic                     rsp_cmp_true
);
   localparam int OW = OPERAND_WIDTH;
   localparam int PW = 2 * OW;          // product magnitude
   localparam int SW = PW + 1;          // sum magnitude
   localparam int DW = SW;              // divider width

   typedef enum logic [3:0] {
      S_IDLE, S_M1, S_M1W, S_M2, S_M2W, S_M3, S_M3W, S_SUM,
      S_GCD, S_GCDW, S_QN, S_QNW, S_QD, S_QDW, S_OUT
   } state_type;

   state_type st_ff;
   logic [3:0] op_ff;
   logic an_s_ff, ad_s_ff, bn_s_ff, bd_s_ff;
   logic [OW-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic [PW-1:0] p1_ff, p2_ff;
   logic [SW-1:0] nm_ff, dm_ff, p_ff, q_ff, rn_ff;
   logic nneg_ff;
   logic lt_ff, eq_ff;
   logic ov_ff;
   logic [rau_pkg::NUM_W-1:0] on_ff;
   logic [rau_pkg::DEN_W-1:0] od_ff;
   logic oc_ff;

   // shared multiplier and divider
   logic mstart, mdone, dstart, ddone;
   logic [OW-1:0] ma, mb;
   logic [PW-1:0] mprod;
   logic [DW-1:0] dd, dv, dq, dr;

   rau_sermul #(.W(OW)) u_mul (
      .clock(clock), .reset(reset), .start(mstart), .mcand(ma), .mplier(mb),
      .done(mdone), .prod(mprod));
   rau_serdiv #(.W(DW)) u_div (
      .clock(clock), .reset(reset), .start(dstart), .dividend(dd), .divisor(dv),
      .done(ddone), .quot(dq), .rem(dr));

   function automatic logic [OW-1:0] mag(input logic [OW-1:0] v);
      mag = v[OW-1] ? (~v + 1'b1) : v;
   endfunction

   logic [3:0] op_w;
   logic is_cmp, is_unary;
   assign op_w = op_ff;
   assign is_cmp = (op_w == rau_pkg::OP_EQ) || (op_w == rau_pkg::OP_NE) ||
                   (op_w == rau_pkg::OP_LT) || (op_w == rau_pkg::OP_LE) ||
                   (op_w == rau_pkg::OP_GT) || (op_w == rau_pkg::OP_GE);
   assign is_unary = (op_w == rau_pkg::OP_INC) || (op_w == rau_pkg::OP_DEC) ||
                     (op_w == rau_pkg::OP_NEG);

   // pick multiplier and divider operands per step
   always_comb begin
      mstart = 1'b0; ma = an_ff; mb = bd_ff;
      dstart = 1'b0; dd = p_ff; dv = q_ff;
      case (st_ff)
         S_M1: begin
            mstart = 1'b1;
            ma = an_ff;
            mb = (op_w == rau_pkg::OP_MUL) ? bn_ff : bd_ff;
         end
         S_M2: begin
            mstart = 1'b1;
            ma = ad_ff;
            mb = (op_w == rau_pkg::OP_DIV) ? bn_ff : bd_ff;
         end
         S_M3: begin
            mstart = 1'b1; ma = ad_ff; mb = bn_ff;
         end
         S_GCD: begin
            dstart = (q_ff != '0); dd = p_ff; dv = q_ff;
         end
         S_QN: begin
            dstart = 1'b1; dd = nm_ff; dv = p_ff;
         end
         S_QD: begin
            dstart = 1'b1; dd = dm_ff; dv = p_ff;
         end
         default: ;
      endcase
   end

   // signs and magnitudes of the two terms of a sum, their signed sum and the denominator sign
   logic t1_neg, t2_neg, dn_neg, sum_neg;
   logic [SW-1:0] t1, t2, sum_mag;
   always_comb begin
      t1_neg = 1'b0; t2_neg = 1'b0; t1 = '0; t2 = '0; dn_neg = 1'b0;
      case (op_w)
         rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
            t1 = {1'b0, p1_ff}; t1_neg = an_s_ff ^ bd_s_ff;
            t2 = {1'b0, mprod}; t2_neg = ad_s_ff ^ bn_s_ff ^ (op_w == rau_pkg::OP_SUB);
            dn_neg = ad_s_ff ^ bd_s_ff;
         end
         rau_pkg::OP_MUL: begin
            t1 = {1'b0, p1_ff}; t1_neg = an_s_ff ^ bn_s_ff;
            dn_neg = ad_s_ff ^ bd_s_ff;
         end
         rau_pkg::OP_DIV: begin
            t1 = {1'b0, p1_ff}; t1_neg = an_s_ff ^ bd_s_ff;
            dn_neg = ad_s_ff ^ bn_s_ff;
         end
         rau_pkg::OP_INC, rau_pkg::OP_DEC: begin
            t1 = SW'(an_ff); t1_neg = an_s_ff;
            t2 = SW'(ad_ff); t2_neg = ad_s_ff ^ (op_w == rau_pkg::OP_DEC);
            dn_neg = ad_s_ff;
         end
         default: begin
            t1 = SW'(an_ff); t1_neg = ~an_s_ff; dn_neg = ad_s_ff;
         end
      endcase
      if (t1_neg == t2_neg) begin
         sum_neg = t1_neg; sum_mag = t1 + t2;
      end else if (t1 >= t2) begin
         sum_neg = t1_neg; sum_mag = t1 - t2;
      end else begin
         sum_neg = t2_neg; sum_mag = t2 - t1;
      end
   end

   // raw signed cross products for the comparisons
   logic signed [PW:0] lhs_s, rhs_s;
   assign lhs_s = an_s_ff ^ bd_s_ff ? -$signed({1'b0, p1_ff}) : $signed({1'b0, p1_ff});
   assign rhs_s = ad_s_ff ^ bn_s_ff ? -$signed({1'b0, p2_ff}) : $signed({1'b0, p2_ff});

   logic cmp_res;
   always_comb begin
      case (op_w)
         rau_pkg::OP_EQ: cmp_res = eq_ff;
         rau_pkg::OP_NE: cmp_res = ~eq_ff;
         rau_pkg::OP_LT: cmp_res = lt_ff;
         rau_pkg::OP_LE: cmp_res = lt_ff | eq_ff;
         rau_pkg::OP_GT: cmp_res = ~(lt_ff | eq_ff);
         rau_pkg::OP_GE: cmp_res = ~lt_ff;
         default:        cmp_res = 1'b0;
      endcase
   end

   // fold the sign into the numerator at the output width
   logic [rau_pkg::NUM_W-1:0] rn_signed;
   assign rn_signed = nneg_ff ? (~rau_pkg::NUM_W'(rn_ff) + 1'b1) : rau_pkg::NUM_W'(rn_ff);

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         ov_ff <= 1'b0;
      end else begin
         if (ov_ff && !rsp_stall) ov_ff <= 1'b0;
         case (st_ff)
            S_IDLE: if (req_valid && !ov_ff) begin
               op_ff <= req_opcode;
               an_ff <= mag(req_a_num); an_s_ff <= req_a_num[OW-1];
               ad_ff <= mag(req_a_den); ad_s_ff <= req_a_den[OW-1];
               bn_ff <= mag(req_b_num); bn_s_ff <= req_b_num[OW-1];
               bd_ff <= mag(req_b_den); bd_s_ff <= req_b_den[OW-1];
               st_ff <= S_M1;
            end
            S_M1: begin
               if (is_unary) st_ff <= S_SUM;
               else if (op_w > 4'(rau_pkg::OP_NEG)) begin
                  on_ff <= '0; od_ff <= rau_pkg::DEN_W'(1); oc_ff <= 1'b0;
                  st_ff <= S_OUT;
               end else st_ff <= S_M1W;
            end
            S_M1W: if (mdone) begin
               p1_ff <= mprod; st_ff <= S_M2;
            end
            S_M2: st_ff <= S_M2W;
            S_M2W: if (mdone) begin
               p2_ff <= mprod;
               if (op_w == rau_pkg::OP_ADD || op_w == rau_pkg::OP_SUB || is_cmp)
                  st_ff <= S_M3;
               else begin
                  dm_ff <= {1'b0, mprod}; st_ff <= S_SUM;
               end
            end
            S_M3: st_ff <= S_M3W;
            S_M3W: if (mdone) begin
               if (is_cmp) begin
                  p2_ff <= mprod;
                  st_ff <= S_SUM;
               end else begin
                  dm_ff <= {1'b0, p2_ff}; p2_ff <= mprod; st_ff <= S_SUM;
               end
            end
            S_SUM: begin
               if (is_cmp) begin
                  lt_ff <= lhs_s < rhs_s; eq_ff <= lhs_s == rhs_s;
                  st_ff <= S_QD; op_ff <= op_ff;
               end else begin
                  nm_ff <= sum_mag;
                  nneg_ff <= sum_neg ^ dn_neg;
                  if (is_unary) dm_ff <= SW'(ad_ff);
                  p_ff <= sum_mag;
                  q_ff <= is_unary ? SW'(ad_ff) : dm_ff;
                  if (sum_mag == '0 || (is_unary ? (ad_ff == '0) : (dm_ff == '0))) begin
                     on_ff <= '0; od_ff <= rau_pkg::DEN_W'(1); oc_ff <= 1'b0;
                     st_ff <= S_OUT;
                  end else st_ff <= S_GCD;
               end
            end
            S_GCD: st_ff <= (q_ff == '0) ? S_QN : S_GCDW;
            S_GCDW: if (ddone) begin
               p_ff <= q_ff; q_ff <= dr; st_ff <= S_GCD;
            end
            S_QN: st_ff <= S_QNW;
            S_QNW: if (ddone) begin
               rn_ff <= dq; st_ff <= S_QD;
            end
            S_QD: begin
               if (is_cmp) begin
                  on_ff <= '0; od_ff <= rau_pkg::DEN_W'(1); oc_ff <= cmp_res;
                  st_ff <= S_OUT;
               end else st_ff <= S_QDW;
            end
            S_QDW: if (ddone) begin
               on_ff <= rn_signed;
               od_ff <= rau_pkg::DEN_W'(dq);
               oc_ff <= 1'b0;
               st_ff <= S_OUT;
            end
            S_OUT: if (!ov_ff) begin
               ov_ff <= 1'b1; st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall    = (st_ff != S_IDLE) || ov_ff;
   assign rsp_valid    = ov_ff;
   assign rsp_res_num  = on_ff;
   assign rsp_res_den  = od_ff;
   assign rsp_cmp_true = oc_ff;
endmodule

// ===== rtl/rau_checker.sv =====
// Port-level checker for the rational arithmetic unit, bound to the top level.
`timescale 1ns / 1ps
module rau_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [32:0] rsp_res_num,
   input logic [30:0] rsp_res_den,
   input logic        rsp_cmp_true
);
   // result denominator is never zero
   a_den_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_res_den != '0) else $error("zero denominator");
   // a true comparison outcome comes with 0/1
   a_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cmp_true |-> rsp_res_num == '0 && rsp_res_den == 31'd1)
      else $error("comparison result not 0/1");
   // an accepted item is not answered in the next cycle
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid) else $error("result too early");
   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_res_num))
      else $error("stalled result changed");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_res_num(rsp_res_num),
   .rsp_res_den(rsp_res_den), .rsp_cmp_true(rsp_cmp_true));
